FILE: rtl/ptrt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task release table: shared definitions
// Field widths, operation and status codes, and the transaction structs.
// ----------------------------------------------------------------------------
package ptrt_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TASK_ID_W  = 4;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TASK_SLOTS = 16;

  localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELAY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CREATED    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_DUE   = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [TIME_W-1:0]    now_ms;
    logic [TIME_W-1:0]    interval_ms;
    logic [TIME_W-1:0]    delay_ms;
    logic [TASK_ID_W-1:0] task_id;
  } ptrt_in_t;

  typedef struct packed {
    logic [TASK_ID_W-1:0] task_id_res;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } ptrt_out_t;

  // One table entry: period and next release time.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] rel_time;
  } ptrt_entry_t;

endpackage

FILE: rtl/periodic_task_release_table_unit.sv
// ----------------------------------------------------------------------------
// Periodic task release table unit
// Task table held in one synchronous memory; a tick scans one entry a cycle.
// ----------------------------------------------------------------------------
// Create: result in the cycle after the transaction, busy stays low.
// Delay on a created task: busy for one cycle after the transaction (entry
// read as it is accepted, then written back if its period is zero), no result.
// Tick over N tasks: busy while one entry a cycle is read and checked;
// results come at most one a cycle, the last marked by last.
// Reset (synchronous, active low) empties the table; entries are not cleared.
module periodic_task_release_table_unit #(
  parameter int unsigned TASK_SLOTS = ptrt_pkg::TASK_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ptrt_pkg::ptrt_in_t  in_data,
  output logic                out_valid,
  output ptrt_pkg::ptrt_out_t out_data
);
  import ptrt_pkg::*;

  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int unsigned CMP_W = (CNT_W > TASK_ID_W) ? CNT_W : TASK_ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DELAY,
    S_SCAN
  } state_t;

  ptrt_entry_t mem [TASK_SLOTS];
  ptrt_entry_t rd_data_r;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [TIME_W-1:0] delay_r, delay_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0]  eval_idx_r, eval_idx_nxt;
  logic              held_vld_r, held_vld_nxt;
  logic [IDX_W-1:0]  held_idx_r, held_idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  ptrt_out_t         out_r, out_nxt;

  logic              rd_en, wr_en, issue, due;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  ptrt_entry_t       wr_data;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign issue = (rd_idx_r < count_r);
  assign due   = (now_r >= rd_data_r.rel_time);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    now_nxt       = now_r;
    delay_nxt     = delay_r;
    idx_nxt       = idx_r;
    rd_idx_nxt    = rd_idx_r;
    eval_vld_nxt  = eval_vld_r;
    eval_idx_nxt  = eval_idx_r;
    held_vld_nxt  = held_vld_r;
    held_idx_nxt  = held_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = rd_idx_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = eval_idx_r;
    wr_data       = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt = in_data.now_ms;
          unique case (in_data.kind)
            KIND_CREATE: begin
              out_valid_nxt = 1'b1;
              out_nxt.last  = 1'b1;
              if (count_r < CNT_W'(TASK_SLOTS)) begin
                wr_en               = 1'b1;
                wr_addr             = count_r[IDX_W-1:0];
                wr_data.period      = in_data.interval_ms;
                wr_data.rel_time    = in_data.now_ms;
                count_nxt           = count_r + CNT_W'(1);
                out_nxt.task_id_res = TASK_ID_W'(count_r);
                out_nxt.status      = ST_CREATED;
              end else begin
                out_nxt.task_id_res = '0;
                out_nxt.status      = ST_FULL;
              end
            end
            KIND_TICK: begin
              rd_idx_nxt   = '0;
              eval_vld_nxt = 1'b0;
              held_vld_nxt = 1'b0;
              state_nxt    = S_SCAN;
            end
            KIND_DELAY: begin
              if (CMP_W'(in_data.task_id) < CMP_W'(count_r)) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_data.task_id);
                idx_nxt   = IDX_W'(in_data.task_id);
                delay_nxt = in_data.delay_ms;
                state_nxt = S_DELAY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DELAY: begin
        // A periodic task would be re-armed after dispatch anyway.
        if (rd_data_r.period == '0) begin
          wr_en            = 1'b1;
          wr_addr          = idx_r;
          wr_data.rel_time = now_r + delay_r;
        end
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (issue) begin
          rd_en        = 1'b1;
          rd_idx_nxt   = rd_idx_r + CNT_W'(1);
          eval_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        eval_vld_nxt = issue;
        if (eval_vld_r) begin
          if (due) begin
            if (rd_data_r.period != '0) begin
              wr_en            = 1'b1;
              wr_data.rel_time = now_r + rd_data_r.period;
            end
            // The previous due task is only sent once another one is found,
            // so that the final transaction can carry last.
            if (held_vld_r) begin
              out_valid_nxt       = 1'b1;
              out_nxt.task_id_res = TASK_ID_W'(held_idx_r);
              out_nxt.status      = ST_DISPATCHED;
              out_nxt.last        = 1'b0;
            end
            held_vld_nxt = 1'b1;
            held_idx_nxt = eval_idx_r;
          end
        end else if (!issue) begin
          out_valid_nxt = 1'b1;
          out_nxt.last  = 1'b1;
          if (held_vld_r) begin
            out_nxt.task_id_res = TASK_ID_W'(held_idx_r);
            out_nxt.status      = ST_DISPATCHED;
          end else begin
            out_nxt.task_id_res = '0;
            out_nxt.status      = ST_NONE_DUE;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      eval_vld_r  <= 1'b0;
      held_vld_r  <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      eval_vld_r  <= eval_vld_nxt;
      held_vld_r  <= held_vld_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
      now_r       <= now_nxt;
      delay_r     <= delay_nxt;
      idx_r       <= idx_nxt;
      eval_idx_r  <= eval_idx_nxt;
      held_idx_r  <= held_idx_nxt;
      out_r       <= out_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TASK_SLOTS))
    else $error("task count beyond table size");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write-back hit the same entry");

  a_full_report: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.kind == KIND_CREATE && count_r == CNT_W'(TASK_SLOTS))
    |=> (out_valid && out_data.status == ST_FULL && out_data.last))
    else $error("full table not reported on create");

  a_none_due_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_NONE_DUE)
    |-> (out_data.last && out_data.task_id_res == '0 && !busy))
    else $error("nothing-due result malformed");

endmodule
